// ----- rtl/core/sme_pkg.sv -----
// Shared constants, types and address and event code helpers for the switch matrix debounce block.
package sme_pkg;

  localparam int MODULE_COUNT = 16;
  localparam int ROW_COUNT    = 8;

  localparam int MODULE_W = 4;
  localparam int ROW_W    = 3;
  localparam int ATTACK_W = 7;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 9;

  // master row first, then one row group per module
  localparam int STORE_DEPTH = ROW_COUNT * (MODULE_COUNT + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [ATTACK_W-1:0] ATTACK_RESET = 7'd4;
  localparam logic [BYTE_W-1:0]   STORE_RESET  = 8'h04;
  localparam int                  ON_BIT       = 7;

  localparam logic [CODE_W-1:0] MASTER_CODE  = 9'h080;
  localparam logic [CODE_W-1:0] RELEASE_CODE = 9'h100;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CODE_W-1:0] code_t;

  // Store address of one switch.
  function automatic addr_t switch_addr(input logic is_master,
                                        input logic [MODULE_W-1:0] module_index,
                                        input logic [ROW_W-1:0] switch_row);
    addr_t a;
    if (is_master) begin
      a = ADDR_W'(switch_row);
    end else begin
      a = ADDR_W'(ROW_COUNT) + ADDR_W'(module_index) * ADDR_W'(ROW_COUNT)
          + ADDR_W'(switch_row);
    end
    return a;
  endfunction

  // Base event code of one switch, release flag not yet applied.
  function automatic code_t switch_code(input logic is_master,
                                        input logic [MODULE_W-1:0] module_index,
                                        input logic [ROW_W-1:0] switch_row);
    code_t c;
    if (is_master) begin
      c = MASTER_CODE | CODE_W'(switch_row);
    end else begin
      c = (CODE_W'(module_index) << ROW_W) | CODE_W'(switch_row);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sme_if.sv -----
// Stream interfaces for switch samples and debounce events.
interface sme_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          is_master;
  logic [sme_pkg::MODULE_W-1:0]  module_index;
  logic [sme_pkg::ROW_W-1:0]     switch_row;
  logic                          level;

  modport source (output valid, is_master, module_index, switch_row, level, input ready);
  modport sink   (input valid, is_master, module_index, switch_row, level, output ready);
endinterface

interface sme_event_if;
  logic                        valid;
  logic                        ready;
  logic [sme_pkg::CODE_W-1:0]  event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

// ----- rtl/core/sme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/switch_matrix_debounce_events.sv -----
// Top level: switch matrix debounce with press and release events.
//
// Channels:
//   samples  - one scanned switch sample per transfer (is_master, module_index,
//              switch_row, level; level 0 = pressed).
//   events   - zero or one event per sample; event_code bit 8 marks a release,
//              master switches carry 0x80 | row, module switches (module << 3) | row.
//   cfg_*    - attack count write; always ready, take it while idle.
// Throughput: one sample per cycle, sustained while the output register can take
//   each event. The limit is the single read-modify-write of the debounce byte
//   store (one RAM read port, one write port), with the byte written in the
//   previous cycle forwarded. Pipeline: a sample transfer loads the stage 1
//   registers and the RAM read; the update then loads the output register.
// Reset: all 136 debounce bytes read as 4 (switch off) through per-entry valid
//   flops cleared at once; attack count returns to 4. No clearing pass.
// Stall: the output register holds a waiting event; a sample still enters while
//   the update stage is free, and the update stage waits only if it has an event
//   and the output register is still full.
module switch_matrix_debounce_events (
  input  logic                            clk,
  input  logic                            rst,
  sme_sample_if.sink                      samples,
  sme_event_if.source                     events,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sme_pkg::ATTACK_W-1:0]    cfg_data
);

  // ---------------- configuration ----------------
  logic [sme_pkg::ATTACK_W-1:0] attack_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_count <= sme_pkg::ATTACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attack_count <= cfg_data;
    end
  end

  // ---------------- stage 0: accept and read ----------------
  logic           in_xfer;
  logic           s0_in_range;
  sme_pkg::addr_t s0_addr;

  assign in_xfer = samples.valid && samples.ready;

  // rows and modules beyond the configured matrix are dropped
  assign s0_in_range = (int'(samples.switch_row) < sme_pkg::ROW_COUNT) &&
                       (samples.is_master ||
                        (int'(samples.module_index) < sme_pkg::MODULE_COUNT));
  assign s0_addr = sme_pkg::switch_addr(samples.is_master, samples.module_index,
                                        samples.switch_row);

  // ---------------- stage 1: registers ----------------
  logic           s1_valid;
  logic           s1_in_range;
  sme_pkg::addr_t s1_addr;
  logic           s1_pressed;
  sme_pkg::code_t s1_code;

  logic           s1_go;
  logic           s1_event;

  assign samples.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_in_range <= s0_in_range;
      s1_addr     <= s0_addr;
      s1_pressed  <= !samples.level;
      s1_code     <= sme_pkg::switch_code(samples.is_master, samples.module_index,
                                          samples.switch_row);
    end
  end

  // ---------------- debounce byte store ----------------
  logic           ram_we;
  sme_pkg::byte_t ram_rdata;
  sme_pkg::byte_t byte_next;

  sme_ram #(
    .WIDTH (sme_pkg::BYTE_W),
    .DEPTH (sme_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (byte_next),
    .re    (in_xfer),
    .raddr (s0_addr),
    .rdata (ram_rdata)
  );

  // entry written since reset; otherwise it reads as the reset byte
  logic [sme_pkg::STORE_DEPTH-1:0] store_valid;

  // last write, kept for forwarding; the RAM reads old data on a same-edge write
  logic           wr_any;
  sme_pkg::addr_t wr_addr;
  sme_pkg::byte_t wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
      wr_any      <= 1'b0;
    end else if (ram_we) begin
      store_valid[s1_addr] <= 1'b1;
      wr_any               <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wr_addr <= s1_addr;
      wr_data <= byte_next;
    end
  end

  // ---------------- stage 1: update ----------------
  sme_pkg::byte_t byte_cur;
  logic           release_hit;

  always_comb begin
    if (wr_any && (wr_addr == s1_addr)) begin
      byte_cur = wr_data;
    end else if (store_valid[s1_addr]) begin
      byte_cur = ram_rdata;
    end else begin
      byte_cur = sme_pkg::STORE_RESET;
    end
  end

  always_comb begin
    byte_next   = byte_cur;
    s1_event    = 1'b0;
    release_hit = 1'b0;
    if (s1_pressed && !byte_cur[sme_pkg::ON_BIT]) begin
      // count down; the wrap into bit 7 is the press
      byte_next = byte_cur - sme_pkg::BYTE_W'(1);
      s1_event  = s1_in_range && byte_next[sme_pkg::ON_BIT];
    end else if (!s1_pressed && byte_cur[sme_pkg::ON_BIT]) begin
      byte_next   = {1'b0, attack_count};
      s1_event    = s1_in_range;
      release_hit = 1'b1;
    end
  end

  // ---------------- output register ----------------
  logic           out_valid;
  sme_pkg::code_t out_code;

  assign s1_go  = s1_valid && (!s1_event || !out_valid || events.ready);
  assign ram_we = s1_go && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_event) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_event) begin
      out_code <= release_hit ? (s1_code | sme_pkg::RELEASE_CODE) : s1_code;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_code = out_code;

endmodule
